/* hdl/arc_pkg.sv */
// Shared types and codes for the ARP resolution cache.
// Used by the top-level sequencer and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package arc_pkg;

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int TAG_W = 16;
  localparam int MS_W  = 16;
  localparam int AGE_W = 17;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [MAC_W-1:0] MAC_BCAST = '1;

  // request codes (in_tuser)
  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RECV = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // received frame kinds
  localparam logic [1:0] FRM_IPV4 = 2'd0;
  localparam logic [1:0] FRM_ARP  = 2'd1;

  // result kinds (out_tuser)
  localparam logic [2:0] KIND_FRAME   = 3'd0;
  localparam logic [2:0] KIND_ARP_REQ = 3'd1;
  localparam logic [2:0] KIND_ARP_RPL = 3'd2;
  localparam logic [2:0] KIND_DELIVER = 3'd3;
  localparam logic [2:0] KIND_DROP    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_MAC = 2'd0;
  localparam logic [1:0] REG_OWN_IP  = 2'd1;
  localparam logic [1:0] REG_RETRY   = 2'd2;
  localparam logic [1:0] REG_EXPIRY  = 2'd3;

  localparam logic [MS_W-1:0] RETRY_RST  = 16'd5000;
  localparam logic [MS_W-1:0] EXPIRY_RST = 16'd30000;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             resolved;
    logic [AGE_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [TAG_W-1:0] tag;
  } wait_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic [TAG_W-1:0] tag;
  } res_t;

endpackage
`default_nettype wire

/* hdl/arc_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
// Holds cache entries and queued datagrams; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/arp_resolve_cache_with_pending_queue.sv */
// ARP resolution cache top level: sequencer, cache valid bits, result staging.
// Depends on arc_pkg and arc_ram.
`timescale 1ns / 1ps
`default_nettype none
// One word in takes one of three requests: send a datagram, receive a parsed
// frame, or a millisecond tick. A single sequencer walks the cache RAM entry
// by entry (read, then evaluate through the shared compare/age unit). Sends
// and ARP receives walk the whole cache and then decide; a send to a hop that
// is not resolved then queues its datagram or drops it, and an ARP receive may
// walk the queue (every queued word is read and checked, released or not). A
// tick walks the whole cache to age it; any other received frame and an unused
// request type skip the walk. in_tready is high only while the sequencer is
// idle. Results are staged one word behind so that tlast marks the final result
// of each input; output stalls hold the sequencer. No clearing pass is needed
// after reset: cache valid bits clear at once and the queue is tracked by a
// count.
module arp_resolve_cache_with_pending_queue #(
  parameter int CACHE_ENTRIES = 16,
  parameter int WAIT_DEPTH    = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input words
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata, low bit up: dgram_tag[15:0], hop_addr[47:16], frame_dst_mac[95:48],
  // frame_kind[97:96], parse_ok[98], arp_is_reply[99], arp_sender_ip[131:100],
  // arp_sender_mac[179:132], arp_target_ip[211:180], elapsed_ms[227:212], pad
  input  wire logic [231:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // req_type[1:0]
  // result words
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata, low bit up: out_dst_mac[47:0], out_target_ip[79:48], out_tag[95:80]
  output logic [95:0]       out_tdata,
  output logic [2:0]        out_tuser,  // out_kind[2:0]
  output logic              out_tlast,  // out_last
  // configuration writes
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [47:0]  cfg_wdata
);

  localparam int CW = $clog2(CACHE_ENTRIES);
  localparam int QA = $clog2(WAIT_DEPTH);
  localparam int QW = $clog2(WAIT_DEPTH + 1);
  localparam logic [CW-1:0] C_LAST = CW'(CACHE_ENTRIES - 1);
  localparam logic [QW-1:0] Q_FULL = QW'(WAIT_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_CRD, S_CEV, S_DEC, S_ENQ, S_QRD, S_QEV, S_RPL, S_TRD, S_TEV, S_FIN
  } state_t;

  state_t state_r;

  // configuration
  logic [arc_pkg::MAC_W-1:0] own_mac_r;
  logic [arc_pkg::IP_W-1:0]  own_ip_r;
  logic [arc_pkg::MS_W-1:0]  retry_r, expiry_r;

  // latched request
  logic [1:0]                req_r;
  logic [arc_pkg::TAG_W-1:0] tag_r;
  logic [arc_pkg::IP_W-1:0]  key_r;
  logic                      reply_r;
  logic [arc_pkg::MAC_W-1:0] smac_r;
  logic [arc_pkg::IP_W-1:0]  tip_r;
  logic [arc_pkg::MS_W-1:0]  elapsed_r;

  // lookup results
  logic [CW-1:0]             cnt_r;
  logic                      hit_r, free_found_r;
  logic [CW-1:0]             hit_idx_r, free_idx_r, old_idx_r;
  logic                      hit_res_r;
  logic [arc_pkg::AGE_W-1:0] hit_age_r, old_age_r;
  logic [arc_pkg::MAC_W-1:0] hit_mac_r;
  logic [CACHE_ENTRIES-1:0]  valid_r;

  // queue bookkeeping
  logic [QW-1:0]             wcount_r, qi_r, qk_r;

  // result staging
  arc_pkg::res_t             hold_r, out_res_r;
  logic                      hold_v_r, out_valid_r, out_last_r;

  // RAM ports
  logic                      c_we, q_we;
  logic [CW-1:0]             c_wa;
  logic [QA-1:0]             q_wa;
  arc_pkg::entry_t           c_wd, c_rd;
  arc_pkg::wait_t            q_wd, q_rd;

  arc_ram #(.WIDTH($bits(arc_pkg::entry_t)), .DEPTH(CACHE_ENTRIES)) u_cache (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(cnt_r), .rdata(c_rd)
  );

  arc_ram #(.WIDTH($bits(arc_pkg::wait_t)), .DEPTH(WAIT_DEPTH)) u_wait (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(qi_r[QA-1:0]), .rdata(q_rd)
  );

  // input field views
  logic [arc_pkg::TAG_W-1:0] in_tag;
  logic [arc_pkg::IP_W-1:0]  in_hop, in_sip, in_tip;
  logic [arc_pkg::MAC_W-1:0] in_fdst, in_smac;
  logic [1:0]                in_fkind;
  logic                      in_ok, in_reply;
  logic [arc_pkg::MS_W-1:0]  in_elapsed;

  assign in_tag     = in_tdata[15:0];
  assign in_hop     = in_tdata[47:16];
  assign in_fdst    = in_tdata[95:48];
  assign in_fkind   = in_tdata[97:96];
  assign in_ok      = in_tdata[98];
  assign in_reply   = in_tdata[99];
  assign in_sip     = in_tdata[131:100];
  assign in_smac    = in_tdata[179:132];
  assign in_tip     = in_tdata[211:180];
  assign in_elapsed = in_tdata[227:212];

  logic in_acc, out_free, for_us;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign for_us    = (in_fdst == own_mac_r) || (in_fdst == arc_pkg::MAC_BCAST);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.tag, out_res_r.ip, out_res_r.mac};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

  // shared compare / age unit
  logic                      cur_valid, ip_match, age_gt;
  logic [arc_pkg::AGE_W:0]   age_sum;
  logic [arc_pkg::AGE_W-1:0] age_sat;
  logic [CW-1:0]             tgt_idx;
  logic                      was_res;

  assign cur_valid = valid_r[cnt_r];
  assign ip_match  = cur_valid && (c_rd.ip == key_r);
  assign age_gt    = c_rd.age > old_age_r;
  assign age_sum   = {1'b0, c_rd.age} + (arc_pkg::AGE_W + 1)'(elapsed_r);
  assign age_sat   = age_sum[arc_pkg::AGE_W] ? arc_pkg::AGE_MAX : age_sum[arc_pkg::AGE_W-1:0];
  assign tgt_idx   = hit_r ? hit_idx_r : (free_found_r ? free_idx_r : old_idx_r);
  assign was_res   = hit_r && hit_res_r;

  logic          emit_req, stall;
  arc_pkg::res_t emit_res;
  logic          send_fast, send_wait;

  assign send_fast = hit_r && hit_res_r;
  assign send_wait = hit_r && !hit_res_r && (hit_age_r < arc_pkg::AGE_W'(retry_r));

  // result selection and RAM writes
  always_comb begin
    emit_req = 1'b0;
    emit_res = '0;
    c_we     = 1'b0;
    c_wa     = tgt_idx;
    c_wd     = c_rd;
    q_we     = 1'b0;
    q_wa     = qk_r[QA-1:0];
    q_wd     = q_rd;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == arc_pkg::REQ_RECV && for_us &&
            in_fkind == arc_pkg::FRM_IPV4 && in_ok) begin
          emit_req     = 1'b1;
          emit_res.kind = arc_pkg::KIND_DELIVER;
          emit_res.tag = in_tag;
        end
      end
      S_DEC: begin
        if (req_r == arc_pkg::REQ_SEND) begin
          if (send_fast) begin
            emit_req      = 1'b1;
            emit_res.kind = arc_pkg::KIND_FRAME;
            emit_res.mac  = hit_mac_r;
            emit_res.tag  = tag_r;
          end else if (!send_wait) begin
            emit_req      = 1'b1;
            emit_res.kind = arc_pkg::KIND_ARP_REQ;
            emit_res.mac  = arc_pkg::MAC_BCAST;
            emit_res.ip   = key_r;
            c_we          = 1'b1;
            c_wd          = '{ip: key_r, mac: '0, resolved: 1'b0, age: '0};
          end
        end else begin
          c_we = 1'b1;
          c_wd = '{ip: key_r, mac: smac_r, resolved: 1'b1, age: '0};
        end
      end
      S_ENQ: begin
        if (wcount_r == Q_FULL) begin
          emit_req      = 1'b1;
          emit_res.kind = arc_pkg::KIND_DROP;
          emit_res.tag  = tag_r;
        end else begin
          q_we = 1'b1;
          q_wa = wcount_r[QA-1:0];
          q_wd = '{ip: key_r, tag: tag_r};
        end
      end
      S_QEV: begin
        if (q_rd.ip == key_r) begin
          emit_req      = 1'b1;
          emit_res.kind = arc_pkg::KIND_FRAME;
          emit_res.mac  = smac_r;
          emit_res.tag  = q_rd.tag;
        end else begin
          q_we = 1'b1;
        end
      end
      S_RPL: begin
        if (!reply_r && tip_r == own_ip_r) begin
          emit_req      = 1'b1;
          emit_res.kind = arc_pkg::KIND_ARP_RPL;
          emit_res.mac  = smac_r;
          emit_res.ip   = key_r;
        end
      end
      S_TEV: begin
        c_wa     = cnt_r;
        c_we     = cur_valid;
        c_wd.age = age_sat;
      end
      default: ;
    endcase
  end

  assign stall = (emit_req && hold_v_r && !out_free) ||
                 (state_r == S_FIN && hold_v_r && !out_free);

  // load the output register from the staged result
  logic out_load;
  assign out_load = !stall && hold_v_r && (emit_req || state_r == S_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      wcount_r    <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      own_mac_r   <= '0;
      own_ip_r    <= '0;
      retry_r     <= arc_pkg::RETRY_RST;
      expiry_r    <= arc_pkg::EXPIRY_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          arc_pkg::REG_OWN_MAC: own_mac_r <= cfg_wdata;
          arc_pkg::REG_OWN_IP:  own_ip_r  <= cfg_wdata[arc_pkg::IP_W-1:0];
          arc_pkg::REG_RETRY:   retry_r   <= cfg_wdata[arc_pkg::MS_W-1:0];
          arc_pkg::REG_EXPIRY:  expiry_r  <= cfg_wdata[arc_pkg::MS_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // push a new result: move the staged one out, keep the new one back
      if (emit_req && !stall) begin
        if (hold_v_r) begin
          out_res_r  <= hold_r;
          out_last_r <= 1'b0;
        end
        hold_r   <= emit_res;
        hold_v_r <= 1'b1;
      end

      if (!stall) begin
        case (state_r)
          S_IDLE: begin
            if (in_acc) begin
              req_r        <= in_tuser;
              tag_r        <= in_tag;
              reply_r      <= in_reply;
              smac_r       <= in_smac;
              tip_r        <= in_tip;
              elapsed_r    <= in_elapsed;
              cnt_r        <= '0;
              hit_r        <= 1'b0;
              free_found_r <= 1'b0;
              case (in_tuser)
                arc_pkg::REQ_SEND: begin
                  key_r   <= in_hop;
                  state_r <= S_CRD;
                end
                arc_pkg::REQ_RECV: begin
                  key_r <= in_sip;
                  if (for_us && in_fkind == arc_pkg::FRM_ARP && in_ok) begin
                    state_r <= S_CRD;
                  end else begin
                    state_r <= S_FIN;
                  end
                end
                arc_pkg::REQ_TICK: state_r <= S_TRD;
                default:           state_r <= S_IDLE;
              endcase
            end
          end
          S_CRD: state_r <= S_CEV;
          S_CEV: begin
            if (ip_match && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= cnt_r;
              hit_res_r <= c_rd.resolved;
              hit_age_r <= c_rd.age;
              hit_mac_r <= c_rd.mac;
            end
            if (!cur_valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= cnt_r;
            end
            if (cnt_r == '0 || age_gt) begin
              old_idx_r <= cnt_r;
              old_age_r <= c_rd.age;
            end
            if (cnt_r == C_LAST) begin
              state_r <= S_DEC;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_CRD;
            end
          end
          S_DEC: begin
            if (c_we) begin
              valid_r[tgt_idx] <= 1'b1;
            end
            if (req_r == arc_pkg::REQ_SEND) begin
              state_r <= send_fast ? S_FIN : S_ENQ;
            end else begin
              qi_r    <= '0;
              qk_r    <= '0;
              state_r <= (!was_res || reply_r) ? S_QRD : S_RPL;
            end
          end
          S_ENQ: begin
            if (wcount_r != Q_FULL) begin
              wcount_r <= wcount_r + 1'b1;
            end
            state_r <= S_FIN;
          end
          S_QRD: begin
            if (qi_r == wcount_r) begin
              wcount_r <= qk_r;
              state_r  <= S_RPL;
            end else begin
              state_r <= S_QEV;
            end
          end
          S_QEV: begin
            if (q_we) begin
              qk_r <= qk_r + 1'b1;
            end
            qi_r    <= qi_r + 1'b1;
            state_r <= S_QRD;
          end
          S_RPL: state_r <= S_FIN;
          S_TRD: state_r <= S_TEV;
          S_TEV: begin
            if (cur_valid && age_sat >= arc_pkg::AGE_W'(expiry_r)) begin
              valid_r[cnt_r] <= 1'b0;
            end
            if (cnt_r == C_LAST) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_TRD;
            end
          end
          S_FIN: begin
            // release the staged result as the last word of this request
            if (hold_v_r) begin
              out_res_r  <= hold_r;
              out_last_r <= 1'b1;
              hold_v_r   <= 1'b0;
            end
            state_r <= S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  // nothing may stay staged once the sequencer is back to idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !hold_v_r)
    else $error("staged result left behind at idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    wcount_r <= Q_FULL)
    else $error("queue count beyond depth");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QEV) |-> (qk_r <= qi_r) && (qi_r < wcount_r))
    else $error("queue compaction pointers out of order");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready || !hold_v_r)
    else $error("accepted word with result still staged");

endmodule
`default_nettype wire

/* dv/arp_resolve_cache_with_pending_queue_tb.sv */
// Self-checking testbench for the ARP resolution cache with pending queue.
// Drives parsed request words, predicts every result word in-line and compares
// them in order; depends on arc_pkg and the arp_resolve_cache_with_pending_queue RTL.
`timescale 1ns / 1ps
module arp_resolve_cache_with_pending_queue_tb;

  localparam int NCACHE = 16;
  localparam int NWAIT  = 16;
  localparam int DRAIN_CYCLES = 120;  // longest walk plus result staging
  localparam int LONG_HOLD = 400;

  // codes the block ignores
  localparam logic [1:0] FRM_OTHER  = 2'd2;
  localparam logic [1:0] FRM_UNDEF  = 2'd3;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                req;
    logic [arc_pkg::TAG_W-1:0] tag;
    logic [arc_pkg::IP_W-1:0]  hop;
    logic [arc_pkg::MAC_W-1:0] fdst;
    logic [1:0]                fkind;
    logic                      ok;
    logic                      rep;
    logic [arc_pkg::IP_W-1:0]  sip;
    logic [arc_pkg::MAC_W-1:0] smac;
    logic [arc_pkg::IP_W-1:0]  tip;
    logic [arc_pkg::MS_W-1:0]  el;
  } req_word_t;

  typedef struct {
    logic [2:0]                kind;
    logic [arc_pkg::MAC_W-1:0] mac;
    logic [arc_pkg::IP_W-1:0]  ip;
    logic [arc_pkg::TAG_W-1:0] tag;
    logic                      last;
  } result_word_t;

  typedef struct {
    logic [arc_pkg::IP_W-1:0]  ip;
    logic [arc_pkg::TAG_W-1:0] tag;
  } parked_t;

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [231:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid, out_tready;
  logic [95:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we;
  logic [1:0]   cfg_addr;
  logic [47:0]  cfg_wdata;

  arp_resolve_cache_with_pending_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block: registers, cache and parked datagrams.
  logic [arc_pkg::MAC_W-1:0] my_mac = '0;
  logic [arc_pkg::IP_W-1:0]  my_ip  = '0;
  logic [arc_pkg::MS_W-1:0]  retry_lim  = arc_pkg::RETRY_RST;
  logic [arc_pkg::MS_W-1:0]  expiry_lim = arc_pkg::EXPIRY_RST;
  logic                      c_valid [NCACHE];
  logic [arc_pkg::IP_W-1:0]  c_ip    [NCACHE];
  logic [arc_pkg::MAC_W-1:0] c_mac   [NCACHE];
  logic                      c_res   [NCACHE];
  logic [arc_pkg::AGE_W-1:0] c_age   [NCACHE];
  parked_t                   parked_q[$];

  result_word_t              expected_q[$];

  bit calm = 0;       // no idling on either side
  bit hold_req = 0;   // ask the receiver for one long stall
  int mismatches = 0;
  int words_sent = 0, results_seen = 0, drops_seen = 0, flushes_seen = 0;

  logic [arc_pkg::IP_W-1:0]  ip_pool  [8];
  logic [arc_pkg::MAC_W-1:0] mac_pool [4];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("arp_resolve_cache_with_pending_queue_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void push_result(logic [2:0] kind, logic [arc_pkg::MAC_W-1:0] mac,
                                      logic [arc_pkg::IP_W-1:0] ip,
                                      logic [arc_pkg::TAG_W-1:0] tag);
    result_word_t r;
    r.kind = kind; r.mac = mac; r.ip = ip; r.tag = tag; r.last = 1'b0;
    expected_q = {expected_q, r};
  endfunction

  function automatic int cache_find(logic [arc_pkg::IP_W-1:0] ip);
    for (int i = 0; i < NCACHE; i++)
      if (c_valid[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  // lowest free slot, else the oldest entry (lowest index on a tie)
  function automatic int cache_victim();
    int best;
    best = 0;
    for (int i = 0; i < NCACHE; i++)
      if (!c_valid[i]) return i;
    for (int i = 1; i < NCACHE; i++)
      if (c_age[i] > c_age[best]) best = i;
    return best;
  endfunction

  function automatic void park(logic [arc_pkg::IP_W-1:0] ip, logic [arc_pkg::TAG_W-1:0] tag);
    parked_t p;
    if (parked_q.size() >= NWAIT) begin
      push_result(arc_pkg::KIND_DROP, '0, '0, tag);
    end else begin
      p.ip = ip; p.tag = tag;
      parked_q = {parked_q, p};
    end
  endfunction

  function automatic void predict_word(req_word_t w);
    int e, n0;
    bit was_res;
    logic [arc_pkg::AGE_W:0] sum;
    parked_t keep[$];
    n0 = expected_q.size();
    if (w.req == arc_pkg::REQ_SEND) begin
      e = cache_find(w.hop);
      if (e >= 0 && c_res[e]) begin
        push_result(arc_pkg::KIND_FRAME, c_mac[e], '0, w.tag);
      end else if (e >= 0 && c_age[e] < {1'b0, retry_lim}) begin
        park(w.hop, w.tag);
      end else begin
        if (e < 0) e = cache_victim();
        c_valid[e] = 1'b1; c_ip[e] = w.hop; c_mac[e] = '0; c_res[e] = 1'b0; c_age[e] = '0;
        push_result(arc_pkg::KIND_ARP_REQ, arc_pkg::MAC_BCAST, w.hop, '0);
        park(w.hop, w.tag);
      end
    end else if (w.req == arc_pkg::REQ_RECV) begin
      if (w.fdst == my_mac || w.fdst == arc_pkg::MAC_BCAST) begin
        if (w.fkind == arc_pkg::FRM_IPV4) begin
          if (w.ok) push_result(arc_pkg::KIND_DELIVER, '0, '0, w.tag);
        end else if (w.fkind == arc_pkg::FRM_ARP && w.ok) begin
          e = cache_find(w.sip);
          was_res = (e >= 0) && c_res[e];
          if (e < 0) e = cache_victim();
          c_valid[e] = 1'b1; c_ip[e] = w.sip; c_mac[e] = w.smac; c_res[e] = 1'b1;
          c_age[e] = '0;
          if (!was_res || w.rep) begin
            // release parked datagrams for the sender, keep the rest in order
            foreach (parked_q[i])
              if (parked_q[i].ip == w.sip)
                push_result(arc_pkg::KIND_FRAME, w.smac, '0, parked_q[i].tag);
              else keep = {keep, parked_q[i]};
            parked_q = keep;
          end
          if (!w.rep && w.tip == my_ip)
            push_result(arc_pkg::KIND_ARP_RPL, w.smac, w.sip, '0);
        end
      end
    end else if (w.req == arc_pkg::REQ_TICK) begin
      for (int i = 0; i < NCACHE; i++) begin
        if (!c_valid[i]) continue;
        sum = c_age[i] + w.el;
        c_age[i] = (sum > arc_pkg::AGE_MAX) ? arc_pkg::AGE_MAX : sum[arc_pkg::AGE_W-1:0];
        if (c_age[i] >= {1'b0, expiry_lim}) c_valid[i] = 1'b0;
      end
    end
    if (expected_q.size() > n0) expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      arc_pkg::REG_OWN_MAC: my_mac = val;
      arc_pkg::REG_OWN_IP:  my_ip = val[arc_pkg::IP_W-1:0];
      arc_pkg::REG_RETRY:   retry_lim = val[arc_pkg::MS_W-1:0];
      arc_pkg::REG_EXPIRY:  expiry_lim = val[arc_pkg::MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [47:0] mac, logic [31:0] ip, logic [15:0] rt, logic [15:0] ex);
    cfg_write(arc_pkg::REG_OWN_MAC, mac);
    cfg_write(arc_pkg::REG_OWN_IP, {16'd0, ip});
    cfg_write(arc_pkg::REG_RETRY, {32'd0, rt});
    cfg_write(arc_pkg::REG_EXPIRY, {32'd0, ex});
  endtask

  // Offer one word, hold it until accepted, then predict its results.
  task automatic send_word(req_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.req;
    in_tdata  <= {4'd0, w.el, w.tip, w.smac, w.sip, w.rep, w.ok, w.fkind, w.fdst, w.hop, w.tag};
    do @(posedge clk); while (!in_tready);
    predict_word(w);
    words_sent++;
  endtask

  // Wait until every expected word has come, plus the walk of a word with none.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic req_word_t blank(logic [1:0] req);
    req_word_t w;
    w.req = req; w.tag = '0; w.hop = '0; w.fdst = my_mac; w.fkind = arc_pkg::FRM_IPV4;
    w.ok = 1'b1; w.rep = 1'b0; w.sip = '0; w.smac = '0; w.tip = '0; w.el = '0;
    return w;
  endfunction

  function automatic req_word_t mk_send(logic [arc_pkg::IP_W-1:0] ip,
                                        logic [arc_pkg::TAG_W-1:0] tag);
    req_word_t w;
    w = blank(arc_pkg::REQ_SEND); w.hop = ip; w.tag = tag;
    return w;
  endfunction

  function automatic req_word_t mk_arp(logic [arc_pkg::MAC_W-1:0] dst, logic rep,
                                       logic [arc_pkg::IP_W-1:0] sip,
                                       logic [arc_pkg::MAC_W-1:0] smac,
                                       logic [arc_pkg::IP_W-1:0] tip);
    req_word_t w;
    w = blank(arc_pkg::REQ_RECV); w.fdst = dst; w.fkind = arc_pkg::FRM_ARP; w.rep = rep;
    w.sip = sip; w.smac = smac; w.tip = tip;
    return w;
  endfunction

  function automatic req_word_t mk_tick(logic [arc_pkg::MS_W-1:0] el);
    req_word_t w;
    w = blank(arc_pkg::REQ_TICK); w.el = el;
    return w;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Mostly well-formed traffic over a small address pool, some noise.
  function automatic req_word_t random_word();
    req_word_t w;
    int pick;
    logic [arc_pkg::MAC_W-1:0] dst;
    pick = $urandom_range(0, 99);
    dst = $urandom_range(0, 1) ? my_mac : arc_pkg::MAC_BCAST;
    if (pick < 38) begin
      w = mk_send(ip_pool[3'($urandom_range(0, 7))], 16'($urandom()));
    end else if (pick < 68) begin
      w = mk_arp(dst, 1'($urandom_range(0, 1)), ip_pool[3'($urandom_range(0, 7))],
                 mac_pool[2'($urandom_range(0, 3))],
                 $urandom_range(0, 2) == 0 ? my_ip : ip_pool[3'($urandom_range(0, 7))]);
    end else if (pick < 76) begin
      w = blank(arc_pkg::REQ_RECV); w.fdst = dst; w.tag = 16'($urandom());
      w.ok = $urandom_range(0, 3) != 0;
    end else if (pick < 88) begin
      w = mk_tick($urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 3000)));
    end else begin
      w.req = 2'($urandom()); w.tag = 16'($urandom()); w.hop = $urandom();
      w.fdst = $urandom_range(0, 1) ? rand48() : dst;
      w.fkind = 2'($urandom()); w.ok = 1'($urandom()); w.rep = 1'($urandom());
      w.sip = $urandom(); w.smac = rand48(); w.tip = $urandom(); w.el = 16'($urandom());
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Resolution path, retry window, replies, filters, ignored kinds, tick extremes.
  task automatic test_resolution_basics();
    req_word_t w;
    set_regs(48'h02_11_22_33_44_55, 32'hC0A8_0001, arc_pkg::RETRY_RST, arc_pkg::EXPIRY_RST);
    send_word(mk_send(ip_pool[0], 16'h0000));  // miss: request and park
    send_word(mk_send(ip_pool[0], 16'h0001));  // pending and young: park only
    send_word(mk_tick(16'd6000));
    send_word(mk_send(ip_pool[0], 16'h0002));  // pending but old: request again
    send_word(mk_arp(my_mac, 1'b1, ip_pool[0], 48'hFFFF_FFFF_FFFE, 32'h0));  // flush three
    send_word(mk_send(ip_pool[0], 16'hFFFF));  // resolved: frame out
    send_word(mk_arp(arc_pkg::MAC_BCAST, 1'b0, ip_pool[1], mac_pool[1], my_ip));  // for us
    send_word(mk_arp(arc_pkg::MAC_BCAST, 1'b0, ip_pool[1], mac_pool[2], my_ip));  // resolved
    send_word(mk_arp(my_mac, 1'b0, ip_pool[2], mac_pool[0], 32'hFFFF_FFFF));  // not for us
    w = blank(arc_pkg::REQ_RECV); w.tag = 16'hFFFF; send_word(w);  // delivery
    w.ok = 1'b0; send_word(w);                            // bad parse: nothing
    w.ok = 1'b1; w.fdst = 48'h0; send_word(w);            // foreign mac: dropped by filter
    w = blank(arc_pkg::REQ_RECV); w.fkind = FRM_OTHER; send_word(w);  // other ethertype
    w.fkind = FRM_UNDEF; send_word(w);
    w = mk_arp(my_mac, 1'b1, ip_pool[3], mac_pool[3], my_ip); w.ok = 1'b0; send_word(w);
    w = random_word(); w.req = REQ_UNUSED; send_word(w);  // unused request type
    send_word(mk_tick(16'd0));
    send_word(mk_tick(16'hFFFF));  // everything expires
    send_word(mk_tick(16'hFFFF));
    drain();
  endtask

  // More distinct hops than cache slots and queue depth: eviction and drops.
  task automatic test_cache_and_queue_full();
    for (int i = 0; i < 18; i++) begin
      send_word(mk_send(32'h0A00_0000 + i, 16'(16'h1000 + i)));
      if (i == 8) send_word(mk_tick(16'd7));  // uneven ages for the victim choice
    end
    send_word(mk_arp(my_mac, 1'b1, 32'h0A00_0003, mac_pool[0], 32'h0));
    send_word(mk_arp(arc_pkg::MAC_BCAST, 1'b0, 32'h0A00_0011, mac_pool[1], my_ip));
    drain();
  endtask

  // Stall the receiver for a long stretch while resolved sends pile up.
  task automatic test_output_backpressure();
    send_word(mk_arp(my_mac, 1'b1, ip_pool[5], mac_pool[2], 32'h0));
    drain();
    hold_req = 1;
    for (int i = 0; i < 20; i++) send_word(mk_send(ip_pool[5], 16'(16'h2000 + i)));
    drain();
  endtask

  task automatic test_random_phase(logic [47:0] mac, logic [31:0] ip, logic [15:0] rt,
                                   logic [15:0] ex, int count);
    set_regs(mac, ip, rt, ex);
    for (int i = 0; i < count; i++) send_word(random_word());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_word_t x;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser == arc_pkg::KIND_DROP) drops_seen++;
      if (out_tuser == arc_pkg::KIND_FRAME) flushes_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind %0d tdata %h last %b",
                   out_tuser, out_tdata, out_tlast);
      end else begin
        x = expected_q.pop_front();
        if (out_tuser !== x.kind || out_tdata !== {x.tag, x.ip, x.mac} || out_tlast !== x.last)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp kind %0d mac %h ip %h tag %h last %b, ",
                      "got kind %0d mac %h ip %h tag %h last %b"},
                     $realtime, x.kind, x.mac, x.ip, x.tag, x.last, out_tuser,
                     out_tdata[47:0], out_tdata[79:48], out_tdata[95:80], out_tlast);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request, none when calm.
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int k = 0; k < LONG_HOLD; k++) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  initial begin
    for (int i = 0; i < NCACHE; i++) begin
      c_valid[i] = 1'b0; c_ip[i] = '0; c_mac[i] = '0; c_res[i] = 1'b0; c_age[i] = '0;
    end
    for (int i = 0; i < 8; i++) ip_pool[i] = 32'hC0A8_0100 + i * 32'h0101_0011;
    ip_pool[7] = 32'hFFFF_FFFF;
    mac_pool[0] = 48'h00_00_00_00_00_01; mac_pool[1] = 48'hA5A5_5A5A_C3C3;
    mac_pool[2] = 48'h5A5A_A5A5_3C3C;    mac_pool[3] = 48'hFFFF_FFFF_FFFE;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= '0;
    cfg_we <= 1'b0; cfg_addr <= '0; cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_resolution_basics();
    test_cache_and_queue_full();
    test_output_backpressure();
    test_random_phase(48'h0, 32'h0, 16'd1, 16'hFFFF, 25);
    test_random_phase(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 25);
    test_random_phase(48'h02_00_5E_10_20_30, ip_pool[4], 16'd0, 16'd2500, 25);
    calm = 1;
    test_random_phase(48'h02_11_22_33_44_55, ip_pool[6], arc_pkg::RETRY_RST,
                      arc_pkg::EXPIRY_RST, 25);

    $display("covered %0d request words, %0d result words (%0d frames, %0d queue drops)",
             words_sent, results_seen, flushes_seen, drops_seen);
    $display("config phases: reset values, retry/expiry extremes, zero retry; one long output hold");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("arp_resolve_cache_with_pending_queue_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, expected_q.size());
      $display("arp_resolve_cache_with_pending_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/arc_pkg.sv
hdl/arc_ram.sv
hdl/arp_resolve_cache_with_pending_queue.sv
dv/arp_resolve_cache_with_pending_queue_tb.sv
